@@ rtl/mhcf_pkg.sv @@
// Package with item types and CRC constants for the message header framer.
`default_nettype none

package mhcf_pkg;

    localparam int unsigned HDR_LENGTH_W = 13;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        last_byte;
        logic [4:0]  subaddress;
        logic [63:0] send_time_us;
    } in_item_t;

    typedef struct packed {
        logic [31:0]             hdr_sync_word;
        logic [4:0]              hdr_opcode;
        logic [HDR_LENGTH_W-1:0] hdr_length;
        logic [31:0]             hdr_sequence;
        logic [31:0]             hdr_crc;
        logic [63:0]             hdr_send_time;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/message_header_crc32_framer_top.sv @@
// Message header framer: per-byte reflected CRC-32 and header generation.
// A last item's header is loaded into the output register when the item leaves the input register.
// Throughput: one item per cycle unless a header is stalled, set by the 8-bit CRC update.
// While a header waits, an empty input register still takes one item, then input stalls.
// Reset: CRC to all ones, byte count and sequence to zero, sync word to zero,
// both item registers empty.
`default_nettype none

module message_header_crc32_framer_top #(
    parameter int unsigned HEADER_BYTES = 48,
    parameter int unsigned MAX_PAYLOAD  = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire mhcf_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output mhcf_pkg::out_item_t      out_item,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned SUM_W =
        ((CNT_W > mhcf_pkg::HDR_LENGTH_W) ? CNT_W : mhcf_pkg::HDR_LENGTH_W) + 1;

    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                  input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ mhcf_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    logic                 in_valid_reg;
    mhcf_pkg::in_item_t   in_reg;
    logic                 out_valid_reg;
    mhcf_pkg::out_item_t  out_reg;
    mhcf_pkg::out_item_t  out_next;
    logic [31:0]          sync_reg;
    logic [31:0]          crc_reg;
    logic [31:0]          crc_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [31:0]          seq_reg;
    logic                 advance;
    logic                 fire;
    logic                 take_byte;
    logic [SUM_W-1:0]     len_sum;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign take_byte = in_reg.has_byte && (count_reg < CNT_W'(MAX_PAYLOAD));

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        if (take_byte)
        begin
            crc_next   = crc_fold_byte(crc_reg, in_reg.payload_byte);
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign len_sum = SUM_W'(count_next) + SUM_W'(HEADER_BYTES);

    always_comb
    begin
        out_next.hdr_sync_word = sync_reg;
        out_next.hdr_opcode    = in_reg.subaddress;
        out_next.hdr_length    = len_sum[mhcf_pkg::HDR_LENGTH_W-1:0];
        out_next.hdr_sequence  = seq_reg;
        out_next.hdr_crc       = ~crc_next;
        out_next.hdr_send_time = in_reg.send_time_us;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sync_reg      <= 32'd0;
            crc_reg       <= mhcf_pkg::CRC_INIT;
            count_reg     <= '0;
            seq_reg       <= 32'd0;
        end
        else
        begin
            if (cfg_we)
                sync_reg <= cfg_data;
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= fire && in_reg.last_byte;
            if (fire)
            begin
                if (in_reg.last_byte)
                begin
                    crc_reg   <= mhcf_pkg::CRC_INIT;
                    count_reg <= '0;
                    seq_reg   <= seq_reg + 32'd1;
                end
                else
                begin
                    crc_reg   <= crc_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_reg <= in_item;
        if (fire && in_reg.last_byte)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PAYLOAD))
        else $error("byte count above maximum payload");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_reg.last_byte |=> count_reg == '0 && crc_reg == mhcf_pkg::CRC_INIT)
        else $error("message state not cleared after last item");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_reg.last_byte |=> seq_reg == $past(seq_reg) + 32'd1)
        else $error("sequence number did not advance");

    a_header_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_reg.last_byte |=> out_valid_reg)
        else $error("last item produced no header");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a held header");

endmodule

`default_nettype wire
